// ===== rtl/kcpq_pkg.sv =====
// kcpq_pkg: shared widths, command codes, controller states and the
// command/status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kcpq_pkg;

  // defaults for the top-level parameters
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_PIXELS_LOG2_DEF = 20;

  // fixed field widths of the channels
  localparam int CMD_W = 2;
  localparam int IDX_W = 8;
  localparam int CH_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_FINALIZE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_UPDATE,
    ST_FIN_READ,
    ST_FIN_START,
    ST_DIVIDE,
    ST_FIN_WRITE,
    ST_EMIT
  } state_t;

  // read address source for the palette and accumulator memories
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_BEST,
    RD_ITEM
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    scan_clear;
    logic    scan_issue;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    pal_load;
    logic    acc_add;
    logic    div_start;
    logic    fin_write;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      in_range;
    logic      scan_last;
    logic      scan_busy;
    logic      div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/kcpq_if.sv =====
// kcpq_req_if / kcpq_rsp_if: valid/ready channels for commands and results.
// Depends on kcpq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kcpq_req_if import kcpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] entry_index;
  logic [CH_W-1:0]  in_red;
  logic [CH_W-1:0]  in_green;
  logic [CH_W-1:0]  in_blue;

  modport source (output valid, cmd, entry_index, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, cmd, entry_index, in_red, in_green, in_blue,
                output ready);
endinterface

interface kcpq_rsp_if import kcpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_index;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic             unchanged;

  modport source (output valid, out_index, out_red, out_green, out_blue, unchanged,
                  input ready);
  modport sink (input valid, out_index, out_red, out_green, out_blue, unchanged,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/kcpq_ctrl.sv =====
// kcpq_ctrl: command sequencer and result-beat valid flag.
// Depends on kcpq_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module kcpq_ctrl import kcpq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    ctl,
  input  dp_status_t sts
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.rd_sel = RD_SCAN;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.cmd)
          CMD_LOAD: state_next = ST_LOAD;
          CMD_CLASSIFY: begin
            ctl.scan_clear = 1'b1;
            state_next     = ST_SCAN;
          end
          CMD_FINALIZE: state_next = sts.in_range ? ST_FIN_READ : ST_EMIT;
          CMD_NONE: state_next = ST_EMIT;
        endcase
      end
      ST_LOAD: begin
        ctl.pal_load = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_SCAN: begin
        ctl.scan_issue = 1'b1;
        ctl.rd_en      = 1'b1;
        ctl.rd_sel     = RD_SCAN;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.scan_busy) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_BEST;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl.acc_add = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_FIN_READ: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_ITEM;
        state_next = ST_FIN_START;
      end
      ST_FIN_START: begin
        ctl.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_next = ST_FIN_WRITE;
        end
      end
      ST_FIN_WRITE: begin
        ctl.fin_write = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result beat valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_DISPATCH))
    else $error("accepted beat not dispatched");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> out_valid)
    else $error("result load did not raise valid");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/kcpq_datapath.sv =====
// kcpq_datapath: palette and accumulator memories, distance scan pipeline,
// three-lane restoring divider and result register. Depends on kcpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kcpq_datapath import kcpq_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
  parameter int MAX_PIXELS_LOG2 = MAX_PIXELS_LOG2_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          ctl,
  output dp_status_t       sts,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [IDX_W-1:0] in_index,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  output logic [IDX_W-1:0] out_index,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue,
  output logic             out_unchanged
);

  localparam int IW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int SW    = MAX_PIXELS_LOG2 + CH_W;
  localparam int CW    = MAX_PIXELS_LOG2 + 1;
  localparam int AW    = 3 * SW + CW;
  localparam int COL_W = 3 * CH_W;
  localparam int SQ_W  = 2 * CH_W;
  localparam int DW    = SQ_W + 2;
  localparam int KW    = $clog2(SW + 1);

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // captured item
  cmd_code_t        item_cmd;
  logic [IDX_W-1:0] item_idx;
  logic [CH_W-1:0]  item_r;
  logic [CH_W-1:0]  item_g;
  logic [CH_W-1:0]  item_b;
  logic             in_range;
  logic [IW-1:0]    item_addr;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_cmd <= cmd_code_t'(in_cmd);
      item_idx <= in_index;
      item_r   <= in_red;
      item_g   <= in_green;
      item_b   <= in_blue;
    end
  end

  assign in_range  = {1'b0, item_idx} < (IDX_W + 1)'(PALETTE_ENTRIES);
  assign item_addr = item_idx[IW-1:0];

  // memories
  logic [COL_W-1:0]           pal_mem [PALETTE_ENTRIES];
  logic [AW-1:0]              acc_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] acc_vld;
  logic [COL_W-1:0]           pal_rd_q;
  logic [AW-1:0]              acc_rd_q;
  logic                       acc_rd_vld;
  logic [IW-1:0]              rd_addr;
  logic [IW-1:0]              scan_addr;
  logic [IW-1:0]              best;
  logic                       pal_we;
  logic [COL_W-1:0]           pal_wdata;
  logic [COL_W-1:0]           mean_col;
  logic                       acc_we;
  logic [AW-1:0]              acc_wdata;
  logic [AW-1:0]              acc_eff;
  logic [SW-1:0]              cur_r;
  logic [SW-1:0]              cur_g;
  logic [SW-1:0]              cur_b;
  logic [CW-1:0]              cur_cnt;

  // read address select
  always_comb begin
    unique case (ctl.rd_sel)
      RD_SCAN: rd_addr = scan_addr;
      RD_BEST: rd_addr = best;
      RD_ITEM: rd_addr = item_addr;
      default: rd_addr = scan_addr;
    endcase
  end

  // palette write: load colour or new mean
  assign pal_we    = (ctl.pal_load && in_range) || ctl.fin_write;
  assign pal_wdata = ctl.fin_write ? mean_col : {item_r, item_g, item_b};

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[item_addr] <= pal_wdata;
    end
    if (ctl.rd_en) begin
      pal_rd_q <= pal_mem[rd_addr];
    end
  end

  // accumulator memory, entries without a valid bit read as zero
  assign acc_eff                        = acc_rd_vld ? acc_rd_q : '0;
  assign {cur_r, cur_g, cur_b, cur_cnt} = acc_eff;
  assign acc_we    = ctl.acc_add && !cur_cnt[CW-1];
  assign acc_wdata = {cur_r + SW'(item_r), cur_g + SW'(item_g), cur_b + SW'(item_b),
                      cur_cnt + CW'(1)};

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[best] <= acc_wdata;
    end
    if (ctl.rd_en) begin
      acc_rd_q <= acc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld    <= '0;
      acc_rd_vld <= 1'b0;
    end else begin
      if (acc_we) begin
        acc_vld[best] <= 1'b1;
      end
      if (ctl.fin_write) begin
        acc_vld[item_addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        acc_rd_vld <= acc_vld[rd_addr];
      end
    end
  end

  // scan pipeline: issue, square, sum and compare
  logic            s1_v;
  logic            s2_v;
  logic [IW-1:0]   s1_a;
  logic [IW-1:0]   s2_a;
  logic [SQ_W-1:0] sq_r;
  logic [SQ_W-1:0] sq_g;
  logic [SQ_W-1:0] sq_b;
  logic [DW-1:0]   dist_sum;
  logic [DW-1:0]   best_d;

  assign dist_sum = DW'(sq_r) + DW'(sq_g) + DW'(sq_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      best      <= '0;
    end else begin
      if (ctl.scan_clear) begin
        scan_addr <= '0;
      end else if (ctl.scan_issue) begin
        scan_addr <= scan_addr + IW'(1);
      end
      s1_v <= ctl.scan_issue;
      s2_v <= s1_v;
      if (s2_v && ((s2_a == '0) || (dist_sum < best_d))) begin
        best <= s2_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_a <= scan_addr;
    s2_a <= s1_a;
    sq_r <= SQ_W'(abs_diff(item_r, pal_rd_q[3*CH_W-1:2*CH_W]))
          * SQ_W'(abs_diff(item_r, pal_rd_q[3*CH_W-1:2*CH_W]));
    sq_g <= SQ_W'(abs_diff(item_g, pal_rd_q[2*CH_W-1:CH_W]))
          * SQ_W'(abs_diff(item_g, pal_rd_q[2*CH_W-1:CH_W]));
    sq_b <= SQ_W'(abs_diff(item_b, pal_rd_q[CH_W-1:0]))
          * SQ_W'(abs_diff(item_b, pal_rd_q[CH_W-1:0]));
    if (s2_v && ((s2_a == '0) || (dist_sum < best_d))) begin
      best_d <= dist_sum;
    end
  end

  // restoring divider, one quotient bit per cycle in each colour lane
  logic [SW-1:0]    dv_num  [3];
  logic [CW-1:0]    dv_rem  [3];
  logic [CH_W-1:0]  dv_q    [3];
  logic [CW:0]      dv_trial[3];
  logic [CW-1:0]    dv_den;
  logic             dv_den_zero;
  logic [KW-1:0]    dv_cnt;
  logic             div_busy;
  logic [COL_W-1:0] old_col;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_trial[i] = {dv_rem[i], dv_num[i][SW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      dv_cnt   <= '0;
    end else if (ctl.div_start) begin
      div_busy <= 1'b1;
      dv_cnt   <= KW'(SW);
    end else if (div_busy) begin
      dv_cnt <= dv_cnt - KW'(1);
      if (dv_cnt == KW'(1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      dv_num[0]   <= cur_r;
      dv_num[1]   <= cur_g;
      dv_num[2]   <= cur_b;
      dv_den      <= cur_cnt;
      dv_den_zero <= (cur_cnt == '0);
      old_col     <= pal_rd_q;
      for (int i = 0; i < 3; i++) begin
        dv_rem[i] <= '0;
        dv_q[i]   <= '0;
      end
    end else if (div_busy) begin
      for (int i = 0; i < 3; i++) begin
        dv_num[i] <= dv_num[i] << 1;
        if (dv_trial[i] >= {1'b0, dv_den}) begin
          dv_rem[i] <= CW'(dv_trial[i] - {1'b0, dv_den});
          dv_q[i]   <= {dv_q[i][CH_W-2:0], 1'b1};
        end else begin
          dv_rem[i] <= dv_trial[i][CW-1:0];
          dv_q[i]   <= {dv_q[i][CH_W-2:0], 1'b0};
        end
      end
    end
  end

  // empty entry gives a zero mean
  assign mean_col = dv_den_zero ? '0 : {dv_q[0], dv_q[1], dv_q[2]};

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_unchanged <= 1'b0;
      unique case (item_cmd)
        CMD_LOAD: begin
          out_index                       <= item_idx;
          {out_red, out_green, out_blue} <= in_range ? {item_r, item_g, item_b} : '0;
        end
        CMD_CLASSIFY: begin
          out_index                       <= IDX_W'(best);
          {out_red, out_green, out_blue} <= pal_rd_q;
        end
        CMD_FINALIZE: begin
          out_index                       <= item_idx;
          {out_red, out_green, out_blue} <= in_range ? mean_col : '0;
          out_unchanged                   <= in_range && (mean_col == old_col);
        end
        CMD_NONE: begin
          out_index                       <= '0;
          {out_red, out_green, out_blue} <= '0;
        end
      endcase
    end
  end

  // status to the controller
  assign sts.cmd       = item_cmd;
  assign sts.in_range  = in_range;
  assign sts.scan_last = (scan_addr == IW'(PALETTE_ENTRIES - 1));
  assign sts.scan_busy = s1_v || s2_v;
  assign sts.div_done  = !div_busy;

`ifndef SYNTHESIS
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    (32'(best) < PALETTE_ENTRIES))
    else $error("best entry beyond palette");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |=> (div_busy && (dv_cnt == KW'(SW))))
    else $error("divider did not start");
  a_fin_idle_div: assert property (@(posedge clk) disable iff (rst)
    ctl.fin_write |-> (!div_busy && in_range))
    else $error("mean written while divider busy or index out of range");
  a_acc_sat: assert property (@(posedge clk) disable iff (rst)
    acc_we |-> !cur_cnt[CW-1])
    else $error("accumulator add past saturation");
`endif

endmodule

`default_nettype wire

// ===== rtl/kmeans_color_palette_quantizer_unit.sv =====
// kmeans_color_palette_quantizer_unit: top level joining controller and datapath.
// Depends on kcpq_pkg, kcpq_if, kcpq_ctrl and kcpq_datapath.
`timescale 1ns / 1ps
`default_nettype none

// One pass of k-means colour quantization over a palette of PALETTE_ENTRIES
// colours. Each accepted command beat gives exactly one result beat. Load
// writes a palette entry. Classify sweeps every palette entry through a single
// read port and one distance-compare pipeline, one entry per cycle, then
// updates the winner's sums. Finalize divides the entry's three sums by its
// member count in a restoring divider that yields one quotient bit per cycle.
// One command is in flight at a time; a finished result waits in an output
// register while the next command is taken. Accumulators come out of reset
// cleared; palette entries must be loaded before they are classified against
// or finalized.
module kmeans_color_palette_quantizer_unit import kcpq_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
  parameter int MAX_PIXELS_LOG2 = MAX_PIXELS_LOG2_DEF
) (
  input logic        clk,
  input logic        rst,
  kcpq_req_if.sink   req,
  kcpq_rsp_if.source rsp
);

  dp_cmd_t    ctl;
  dp_status_t sts;

  kcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  kcpq_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .in_cmd        (req.cmd),
    .in_index      (req.entry_index),
    .in_red        (req.in_red),
    .in_green      (req.in_green),
    .in_blue       (req.in_blue),
    .out_index     (rsp.out_index),
    .out_red       (rsp.out_red),
    .out_green     (rsp.out_green),
    .out_blue      (rsp.out_blue),
    .out_unchanged (rsp.unchanged)
  );

endmodule

`default_nettype wire
